/* rtl/core/assert_macros.svh */
// assertion macros of the core, included by its top rtl file
// every macro samples on clk and is off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge
`define PIDPI_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: condition does not hold");

// consequent must hold at the edge after the antecedent
`define PIDPI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: consequent does not follow");

`endif

/* rtl/core/pidpi_pkg.sv */
// ----------------------------------------------------------------------------
// pidpi_pkg
// Widths, codes and shared types of the positional / incremental pid core.
// ----------------------------------------------------------------------------
`default_nettype none

package pidpi_pkg;

  // field and datapath widths
  localparam int ERR_W      = 17;
  localparam int ACC_W      = 22;
  localparam int SUM_IN_W   = 23;
  localparam int OP_W       = 22;
  localparam int GAIN_W     = 16;
  localparam int PROD_W     = OP_W + GAIN_W;
  localparam int SUM_W      = PROD_W + 3;
  localparam int FRAC_W     = 8;
  localparam int SHIFT_W    = SUM_W - FRAC_W;
  localparam int DRIVE_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int ZR_W       = 6;
  localparam int LIM_W      = 21;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // default depth of the queue between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // zero run counter limits
  localparam logic [ZR_W-1:0] ZERO_RUN_MAX   = 6'd63;
  localparam logic [ZR_W-1:0] ZERO_RUN_LIMIT = 6'd50;

  // reset value of the integral bound
  localparam logic [LIM_W-1:0] LIMIT_RESET = 21'h1FFFFF;

  // mode codes, 3 is unknown and behaves as disabled
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_POS = 2'd0;
  localparam mode_t MODE_INC = 2'd1;
  localparam mode_t MODE_OFF = 2'd2;

  // input command codes
  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_GAIN_P = 3'd1,
    CFG_GAIN_I = 3'd2,
    CFG_GAIN_D = 3'd3,
    CFG_LIMIT  = 3'd4
  } cfg_idx_t;

  // classified work item handed from front to back
  typedef struct packed {
    logic signed [OP_W-1:0]  op_p;
    logic signed [OP_W-1:0]  op_i;
    logic signed [OP_W-1:0]  op_d;
    logic signed [ERR_W-1:0] err;
  } entry_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // front loop state, for checking
  typedef struct packed {
    logic signed [ACC_W-1:0] accum;
    logic [ZR_W-1:0]         zero_run;
  } front_stat_t;

endpackage

`default_nettype wire

/* rtl/core/pidpi_queue.sv */
// ----------------------------------------------------------------------------
// pidpi_queue
// Short register queue carrying classified work items from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_queue #(
  parameter int DEPTH = pidpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  pidpi_pkg::entry_t    push_entry,
  input  wire                  pop,
  output pidpi_pkg::entry_t    pop_entry,
  output pidpi_pkg::q_stat_t   stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pidpi_pkg::entry_t slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // status
  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_entry  = slot_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pidpi_front.sv */
// ----------------------------------------------------------------------------
// pidpi_front
// Accepts input beats, forms the error, runs the integral and zero run
// recurrence and turns each beat into three multiplier operands.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_front (
  input  wire                                       clk,
  input  wire                                       rst_n,
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire                                       in_cmd,
  input  wire signed [pidpi_pkg::SAMPLE_W-1:0]      in_target,
  input  wire signed [pidpi_pkg::SAMPLE_W-1:0]      in_measured,
  input  pidpi_pkg::mode_t                          mode,
  input  wire        [pidpi_pkg::LIM_W-1:0]         limit,
  input  pidpi_pkg::q_stat_t                        q_stat,
  output logic                                      push,
  output pidpi_pkg::entry_t                         push_entry,
  output pidpi_pkg::front_stat_t                    stat
);

  localparam int ERR_W = pidpi_pkg::ERR_W;
  localparam int ACC_W = pidpi_pkg::ACC_W;
  localparam int SIN_W = pidpi_pkg::SUM_IN_W;
  localparam int OP_W  = pidpi_pkg::OP_W;
  localparam int ZR_W  = pidpi_pkg::ZR_W;

  logic signed [ERR_W-1:0] prev_r, prev_nxt;
  logic signed [ERR_W-1:0] prev2_r, prev2_nxt;
  logic signed [ACC_W-1:0] accum_r, accum_nxt;
  logic [ZR_W-1:0]         zrun_r, zrun_nxt;

  logic signed [ERR_W-1:0] err;
  logic [ZR_W-1:0]         zr_inc;
  logic [ZR_W-1:0]         zr_cnt;
  logic [ZR_W-1:0]         zr_pos;
  logic signed [SIN_W-1:0] sum_raw;
  logic signed [SIN_W-1:0] sum_run;
  logic signed [SIN_W-1:0] sum_cl;
  logic signed [SIN_W-1:0] lim_s;
  logic signed [ERR_W:0]   diff1;
  logic signed [ERR_W+1:0] diff2;

  // accept when the queue has room
  assign in_ready = !q_stat.full;
  assign push     = in_valid && in_ready;

  assign stat.accum    = accum_r;
  assign stat.zero_run = zrun_r;

  // error, zero run and clamped integral
  always_comb begin
    err     = ERR_W'(in_target) - ERR_W'(in_measured);
    zr_inc  = (zrun_r == pidpi_pkg::ZERO_RUN_MAX) ? zrun_r : zrun_r + 1'b1;
    zr_cnt  = (err == '0) ? zr_inc : '0;
    sum_raw = SIN_W'(accum_r) + SIN_W'(err);
    lim_s   = signed'(SIN_W'(limit));
    // a long run of zero errors drops the integral
    if ((err == '0) && (zr_inc > pidpi_pkg::ZERO_RUN_LIMIT)) begin
      sum_run = '0;
      zr_pos  = '0;
    end else begin
      sum_run = sum_raw;
      zr_pos  = zr_cnt;
    end
    if (sum_run > lim_s) begin
      sum_cl = lim_s;
    end else if (sum_run < -lim_s) begin
      sum_cl = -lim_s;
    end else begin
      sum_cl = sum_run;
    end
    diff1 = (ERR_W + 1)'(err) - (ERR_W + 1)'(prev_r);
    diff2 = (ERR_W + 2)'(err) - ((ERR_W + 2)'(prev_r) <<< 1) + (ERR_W + 2)'(prev2_r);
  end

  // classify the beat and build the operands
  always_comb begin
    prev_nxt         = prev_r;
    prev2_nxt        = prev2_r;
    accum_nxt        = accum_r;
    zrun_nxt         = zrun_r;
    push_entry.op_p  = '0;
    push_entry.op_i  = '0;
    push_entry.op_d  = '0;
    push_entry.err   = err;
    if (in_cmd == pidpi_pkg::CMD_CLEAR) begin
      prev_nxt       = '0;
      prev2_nxt      = '0;
      accum_nxt      = '0;
      zrun_nxt       = '0;
      push_entry.err = '0;
    end else begin
      unique case (mode)
        pidpi_pkg::MODE_POS: begin
          accum_nxt       = ACC_W'(sum_cl);
          zrun_nxt        = zr_pos;
          prev_nxt        = err;
          push_entry.op_p = OP_W'(err);
          push_entry.op_i = OP_W'(sum_cl);
          push_entry.op_d = OP_W'(diff1);
        end
        pidpi_pkg::MODE_INC: begin
          zrun_nxt        = zr_cnt;
          prev2_nxt       = prev_r;
          prev_nxt        = err;
          push_entry.op_p = OP_W'(diff1);
          push_entry.op_i = OP_W'(err);
          push_entry.op_d = OP_W'(diff2);
        end
        default: begin
          // disabled or unknown mode: zero operands, state held
          push_entry.op_p = '0;
        end
      endcase
    end
  end

  // loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      prev2_r <= '0;
      accum_r <= '0;
      zrun_r  <= '0;
    end else if (push) begin
      prev_r  <= prev_nxt;
      prev2_r <= prev2_nxt;
      accum_r <= accum_nxt;
      zrun_r  <= zrun_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pidpi_back.sv */
// ----------------------------------------------------------------------------
// pidpi_back
// Multiplies the operands by the gains, sums, floors by the fraction bits,
// saturates to 32 bits and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidpi_back (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire signed [pidpi_pkg::GAIN_W-1:0]      gain_p,
  input  wire signed [pidpi_pkg::GAIN_W-1:0]      gain_i,
  input  wire signed [pidpi_pkg::GAIN_W-1:0]      gain_d,
  input  pidpi_pkg::q_stat_t                      q_stat,
  input  pidpi_pkg::entry_t                       q_entry,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic signed [pidpi_pkg::DRIVE_W-1:0]    out_drive,
  output logic signed [pidpi_pkg::ERR_W-1:0]      out_error_now
);

  localparam int PROD_W  = pidpi_pkg::PROD_W;
  localparam int SUM_W   = pidpi_pkg::SUM_W;
  localparam int SHIFT_W = pidpi_pkg::SHIFT_W;
  localparam int DRIVE_W = pidpi_pkg::DRIVE_W;
  localparam int ERR_W   = pidpi_pkg::ERR_W;
  localparam int FRAC_W  = pidpi_pkg::FRAC_W;

  logic                      mul_v_r;
  logic signed [PROD_W-1:0]  prod_p_r, prod_i_r, prod_d_r;
  logic signed [ERR_W-1:0]   merr_r;
  logic                      out_v_r;
  logic signed [DRIVE_W-1:0] drive_r, drive_nxt;
  logic signed [ERR_W-1:0]   oerr_r;

  logic                      out_en;
  logic                      mul_en;
  logic signed [SUM_W-1:0]   sum;
  logic signed [SHIFT_W-1:0] shifted;

  // stall chain from the output register back to the queue
  assign out_en = !out_v_r || out_ready;
  assign mul_en = !mul_v_r || out_en;
  assign q_pop  = mul_en && !q_stat.empty;

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (mul_en) begin
      mul_v_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_p_r <= q_entry.op_p * gain_p;
      prod_i_r <= q_entry.op_i * gain_i;
      prod_d_r <= q_entry.op_d * gain_d;
      merr_r   <= q_entry.err;
    end
  end

  // sum, floor shift and saturate
  always_comb begin
    sum     = SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);
    shifted = sum[SUM_W-1:FRAC_W];
    if (shifted[SHIFT_W-1] && !(&shifted[SHIFT_W-2:DRIVE_W-1])) begin
      drive_nxt = {1'b1, {(DRIVE_W-1){1'b0}}};
    end else if (!shifted[SHIFT_W-1] && (|shifted[SHIFT_W-2:DRIVE_W-1])) begin
      drive_nxt = {1'b0, {(DRIVE_W-1){1'b1}}};
    end else begin
      drive_nxt = shifted[DRIVE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_en) begin
      out_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && mul_v_r) begin
      drive_r <= drive_nxt;
      oerr_r  <= merr_r;
    end
  end

  assign out_valid     = out_v_r;
  assign out_drive     = drive_r;
  assign out_error_now = oerr_r;

endmodule

`default_nettype wire

/* rtl/core/pid_position_incremental_core.sv */
// ----------------------------------------------------------------------------
// pid_position_incremental_core
// Fixed point pid controller, positional or incremental, one sample a cycle unless stalled.
// ----------------------------------------------------------------------------
// The core takes one sample beat per clock cycle while the queue has room and
// returns one result beat for each, in order. The front stage forms the error
// and updates the integral in the accept cycle and writes the work item into
// the queue; the back stage takes it from the queue into the product registers
// and sums, floors and saturates the products into the output register.
// The one-cycle rate is set by the error / integral / zero run recurrence in
// the front stage, which each sample must close before the next. A short
// queue lets the front keep taking samples while the output is stalled.
// Gains are signed Q8.8; write configuration only while no beat is in flight.
`default_nettype none

`include "assert_macros.svh"

module pid_position_incremental_core #(
  parameter int QUEUE_DEPTH = pidpi_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                       clk,
  input  wire                                       rst_n,
  // configuration
  input  wire                                       cfg_we,
  input  wire        [pidpi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire        [pidpi_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // sample channel
  input  wire                                       in_valid,
  output logic                                      in_ready,
  input  wire                                       in_cmd,
  input  wire signed [pidpi_pkg::SAMPLE_W-1:0]      in_target,
  input  wire signed [pidpi_pkg::SAMPLE_W-1:0]      in_measured,
  // result channel
  output logic                                      out_valid,
  input  wire                                       out_ready,
  output logic signed [pidpi_pkg::DRIVE_W-1:0]      out_drive,
  output logic signed [pidpi_pkg::ERR_W-1:0]        out_error_now
);

  localparam int GAIN_W = pidpi_pkg::GAIN_W;
  localparam int LIM_W  = pidpi_pkg::LIM_W;
  localparam int ACC_W  = pidpi_pkg::ACC_W;

  pidpi_pkg::mode_t          mode_r;
  logic signed [GAIN_W-1:0]  gain_p_r, gain_i_r, gain_d_r;
  logic [LIM_W-1:0]          limit_r;

  logic                      push;
  logic                      q_pop;
  pidpi_pkg::entry_t         push_entry;
  pidpi_pkg::entry_t         pop_entry;
  pidpi_pkg::q_stat_t        q_stat;
  pidpi_pkg::front_stat_t    f_stat;
  logic signed [ACC_W-1:0]   lim_pos;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= pidpi_pkg::MODE_POS;
      gain_p_r <= '0;
      gain_i_r <= '0;
      gain_d_r <= '0;
      limit_r  <= pidpi_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pidpi_pkg::CFG_MODE:   mode_r   <= cfg_wdata[pidpi_pkg::MODE_W-1:0];
        pidpi_pkg::CFG_GAIN_P: gain_p_r <= cfg_wdata[GAIN_W-1:0];
        pidpi_pkg::CFG_GAIN_I: gain_i_r <= cfg_wdata[GAIN_W-1:0];
        pidpi_pkg::CFG_GAIN_D: gain_d_r <= cfg_wdata[GAIN_W-1:0];
        pidpi_pkg::CFG_LIMIT:  limit_r  <= cfg_wdata[LIM_W-1:0];
        default: begin
          // writes past the register list are dropped
          mode_r <= mode_r;
        end
      endcase
    end
  end

  // front: accept and classify
  pidpi_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_target   (in_target),
    .in_measured (in_measured),
    .mode        (mode_r),
    .limit       (limit_r),
    .q_stat      (q_stat),
    .push        (push),
    .push_entry  (push_entry),
    .stat        (f_stat)
  );

  // queue between front and back
  pidpi_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .stat       (q_stat)
  );

  // back: multiply, sum and saturate
  pidpi_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .gain_p        (gain_p_r),
    .gain_i        (gain_i_r),
    .gain_d        (gain_d_r),
    .q_stat        (q_stat),
    .q_entry       (pop_entry),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_drive     (out_drive),
    .out_error_now (out_error_now)
  );

  // integral bound as a signed value
  assign lim_pos = signed'(ACC_W'(limit_r));

  // checks
  `PIDPI_ASSERT(a_no_pop_when_empty, !(q_pop && q_stat.empty))
  `PIDPI_ASSERT(a_queue_status_sane, !(q_stat.full && q_stat.empty))
  `PIDPI_ASSERT_NEXT(a_clear_zeroes_state, push && (in_cmd == pidpi_pkg::CMD_CLEAR), (f_stat.accum == '0) && (f_stat.zero_run == '0))
  `PIDPI_ASSERT_NEXT(a_integral_in_bound, push && (in_cmd == pidpi_pkg::CMD_STEP) && (mode_r == pidpi_pkg::MODE_POS), (f_stat.accum <= $past(lim_pos)) && (f_stat.accum >= -$past(lim_pos)))

endmodule

`default_nettype wire
